// ===== design/greedy_nearest_track_assign_assert.svh =====
// Assertion macros used by the track assignment design file.
`ifndef GREEDY_NEAREST_TRACK_ASSIGN_ASSERT_SVH
`define GREEDY_NEAREST_TRACK_ASSIGN_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GNTA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define GNTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/gnta_pkg.sv =====
package gnta_pkg;

	// Fixed field widths.
	localparam int unsigned COORD_W = 16;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned CFG_W   = 5;
	localparam int unsigned SQ_W    = 2 * COORD_W;
	localparam int unsigned COST_W  = SQ_W + 2;

	// Active track count after reset.
	localparam int unsigned ACTIVE_RESET = 10;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COST_W-1:0]  cost_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BUILD,
		ST_DRAIN,
		ST_SCAN,
		ST_SWAIT,
		ST_FETCH,
		ST_UPDATE,
		ST_EMIT
	} state_t;

endpackage

// ===== design/gnta_if.sv =====
// Particle input channel.
interface gnta_in_if;
	import gnta_pkg::*;
	logic   valid;
	logic   ready;
	coord_t pos_x;
	coord_t pos_y;
	logic   frame_end;
	modport source (output valid, pos_x, pos_y, frame_end, input ready);
	modport sink (input valid, pos_x, pos_y, frame_end, output ready);
endinterface

// Association result channel.
interface gnta_out_if;
	import gnta_pkg::*;
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] particle_index;
	logic [INDEX_W-1:0] track_index;
	logic               dropped_extra;
	logic               run_last;
	modport source (output valid, particle_index, track_index, dropped_extra, run_last,
		input ready);
	modport sink (input valid, particle_index, track_index, dropped_extra, run_last,
		output ready);
endinterface

// Configuration write channel for active_tracks.
interface gnta_cfg_if;
	import gnta_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/greedy_nearest_track_assign.sv =====
// Particles load one per cycle while the block is in its load state (ready is low otherwise).
// On frame close the cost table is built, then each pick scans the cost memory
// before its output handshake (one memory read per cycle).
// Reset (arst_n low) clears control state, track point flags and sets active_tracks to 10;
// point and buffer memories are not cleared.
module greedy_nearest_track_assign #(
	parameter int unsigned MAX_TRACKS    = 16,
	parameter int unsigned MAX_PARTICLES = 16
) (
	input logic       clk,
	input logic       arst_n,
	gnta_cfg_if.sink  cfg,
	gnta_in_if.sink   particles,
	gnta_out_if.source assoc
);
	import gnta_pkg::*;

	localparam int unsigned TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int unsigned PW  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned TCW = $clog2(MAX_TRACKS + 1);
	localparam int unsigned PCW = $clog2(MAX_PARTICLES + 1);
	localparam int unsigned KW  = (TCW > PCW) ? TCW : PCW;
	localparam int unsigned AW  = TW + PW;
	localparam int unsigned AT_RESET = (ACTIVE_RESET < MAX_TRACKS) ? ACTIVE_RESET : MAX_TRACKS;

	state_t state_q, state_d;

	logic [TCW-1:0] at_q;
	logic [TCW-1:0] nt_q;
	logic [PCW-1:0] cnt_q;
	logic           ovf_q;
	logic [TW-1:0]  t_q;
	logic [PW-1:0]  p_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  picks;

	logic [MAX_TRACKS-1:0]    hasp_q;
	logic [MAX_TRACKS-1:0]    tused_q;
	logic [MAX_PARTICLES-1:0] pused_q;

	// Memories and their registered read data.
	logic [2*COORD_W-1:0] frm_mem [2**PW];
	logic [2*COORD_W-1:0] trk_mem [2**TW];
	cost_t                cost_mem [2**AW];
	logic [2*COORD_W-1:0] frm_rd_q;
	logic [2*COORD_W-1:0] trk_rd_q;
	cost_t                cost_rd_q;
	logic [PW-1:0]        frm_ra;

	// Cost build pipeline.
	logic          v_s1, v_s2, v_s3;
	logic          has_s1, has_s2, has_s3;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	coord_t        dx_s2, dy_s2;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;

	// Scan compare stage and best pair.
	logic          sv_s1;
	logic [TW-1:0] st_s1;
	logic [PW-1:0] sp_s1;
	logic          found_q;
	cost_t         best_q;
	logic [TW-1:0] bt_q;
	logic [PW-1:0] bp_q;

	// Output register.
	logic [INDEX_W-1:0] out_p_q, out_t_q;
	logic               out_last_q;

	logic in_acc, out_acc, t_last, p_last, p_room;
	logic [CFG_W-1:0] cfg_v;

	assign in_acc  = particles.valid && particles.ready;
	assign out_acc = assoc.valid && assoc.ready;
	assign t_last  = (TCW'(t_q) + TCW'(1)) == nt_q;
	assign p_last  = (PCW'(p_q) + PCW'(1)) == cnt_q;
	assign p_room  = cnt_q != PCW'(MAX_PARTICLES);
	assign picks   = (KW'(nt_q) < KW'(cnt_q)) ? KW'(nt_q) : KW'(cnt_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:   if (in_acc && particles.frame_end) state_d = ST_BUILD;
			ST_BUILD:  if (t_last && p_last) state_d = ST_DRAIN;
			ST_DRAIN:  if (!v_s1 && !v_s2 && !v_s3) state_d = ST_SCAN;
			ST_SCAN:   if (t_last && p_last) state_d = ST_SWAIT;
			ST_SWAIT:  state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_acc) state_d = out_last_q ? ST_LOAD : ST_SCAN;
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		particles.ready = (state_q == ST_LOAD);
		assoc.valid     = (state_q == ST_EMIT);
		cfg.ready       = 1'b1;
	end

	assign assoc.particle_index = out_p_q;
	assign assoc.track_index    = out_t_q;
	assign assoc.dropped_extra  = ovf_q;
	assign assoc.run_last       = out_last_q;

	// Clamped register write value.
	assign cfg_v = (cfg.data == '0) ? CFG_W'(1) : cfg.data;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			at_q    <= TCW'(AT_RESET);
			nt_q    <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			t_q     <= '0;
			p_q     <= '0;
			k_q     <= '0;
			hasp_q  <= '0;
			tused_q <= '0;
			pused_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			sv_s1   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				if (int'(cfg_v) > int'(MAX_TRACKS)) at_q <= TCW'(MAX_TRACKS);
				else at_q <= TCW'(cfg_v);
			end
			v_s1  <= (state_q == ST_BUILD);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			sv_s1 <= (state_q == ST_SCAN) && !tused_q[t_q] && !pused_q[p_q];
			// Scan compare on returned cost; strict less keeps the earliest pair.
			if (sv_s1 && (!found_q || cost_rd_q < best_q)) found_q <= 1'b1;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (p_room) cnt_q <= cnt_q + PCW'(1);
						else ovf_q <= 1'b1;
						if (particles.frame_end) begin
							nt_q    <= at_q;
							t_q     <= '0;
							p_q     <= '0;
							k_q     <= '0;
							tused_q <= '0;
							pused_q <= '0;
						end
					end
				end
				ST_BUILD, ST_SCAN: begin
					if (p_last) begin
						p_q <= '0;
						t_q <= t_last ? '0 : t_q + TW'(1);
					end else begin
						p_q <= p_q + PW'(1);
					end
				end
				ST_DRAIN: found_q <= 1'b0;
				ST_UPDATE: begin
					hasp_q[bt_q]  <= 1'b1;
					tused_q[bt_q] <= 1'b1;
					pused_q[bp_q] <= 1'b1;
					k_q           <= k_q + KW'(1);
				end
				ST_EMIT: begin
					if (out_acc) begin
						found_q <= 1'b0;
						if (out_last_q) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Frame buffer memory: written on load, read during build and fetch.
	assign frm_ra = (state_q == ST_FETCH) ? bp_q : p_q;
	always_ff @(posedge clk) begin
		if (in_acc && p_room) begin
			frm_mem[cnt_q[PW-1:0]] <= {particles.pos_x, particles.pos_y};
		end
		frm_rd_q <= frm_mem[frm_ra];
	end

	// Track point memory: read during build, written on each pick.
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) trk_mem[bt_q] <= frm_rd_q;
		trk_rd_q <= trk_mem[t_q];
	end

	// Cost memory: written by the build pipeline, read during scan.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			cost_mem[addr_s3] <= has_s3 ? (COST_W'(sqx_s3) + COST_W'(sqy_s3) + COST_W'(1))
				: '0;
		end
		cost_rd_q <= cost_mem[{t_q, p_q}];
	end

	// Build pipeline payload: read, absolute difference, square.
	always_ff @(posedge clk) begin
		has_s1  <= hasp_q[t_q];
		addr_s1 <= {t_q, p_q};
		has_s2  <= has_s1;
		addr_s2 <= addr_s1;
		dx_s2   <= (trk_rd_q[2*COORD_W-1:COORD_W] >= frm_rd_q[2*COORD_W-1:COORD_W])
			? trk_rd_q[2*COORD_W-1:COORD_W] - frm_rd_q[2*COORD_W-1:COORD_W]
			: frm_rd_q[2*COORD_W-1:COORD_W] - trk_rd_q[2*COORD_W-1:COORD_W];
		dy_s2   <= (trk_rd_q[COORD_W-1:0] >= frm_rd_q[COORD_W-1:0])
			? trk_rd_q[COORD_W-1:0] - frm_rd_q[COORD_W-1:0]
			: frm_rd_q[COORD_W-1:0] - trk_rd_q[COORD_W-1:0];
		has_s3  <= has_s2;
		addr_s3 <= addr_s2;
		sqx_s3  <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3  <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	// Scan payload: pair under test and best pair so far.
	always_ff @(posedge clk) begin
		st_s1 <= t_q;
		sp_s1 <= p_q;
		if (sv_s1 && (!found_q || cost_rd_q < best_q)) begin
			best_q <= cost_rd_q;
			bt_q   <= st_s1;
			bp_q   <= sp_s1;
		end
		if (state_q == ST_UPDATE) begin
			out_p_q    <= INDEX_W'(bp_q);
			out_t_q    <= INDEX_W'(bt_q);
			out_last_q <= (k_q + KW'(1)) == picks;
		end
	end

	`include "greedy_nearest_track_assign_assert.svh"

	`GNTA_ASSERT_NOW(a_pick_in_range, assoc.valid, (TCW'(bt_q) < nt_q) && (PCW'(bp_q) < cnt_q))
	`GNTA_ASSERT_NOW(a_no_overlap, assoc.valid, !particles.ready && !v_s3)
	`GNTA_ASSERT_NEXT(a_next_pick, out_acc && !out_last_q, state_q == ST_SCAN)
	`GNTA_ASSERT_NOW(a_found_before_fetch, state_q == ST_FETCH, found_q)

endmodule
